// ===== hw/rtl/hxas_pkg.sv =====
// shared types and constants for the heat exchanger antifreeze sequencer
`timescale 1ns / 1ps
`default_nettype none
package hxas_pkg;

    localparam int TEMP_W = 12;
    localparam int TIME_W = 32;
    localparam int MODE_W = 2;
    localparam int HYST_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [MODE_W-1:0] MODE_OFF       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREHEATER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FAN_OFF   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FIREPLACE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIREPLACE  = 2'd1;

    localparam logic [HYST_W-1:0] HYST_RESET = 4'd3;
    localparam logic [HYST_W-1:0] HYST_MAX   = 4'd10;

    // temperatures in tenths of a degree
    localparam logic signed [TEMP_W-1:0] THRESHOLD_TENTHS     = 12'sd15;
    localparam logic signed [TEMP_W-1:0] OUTSIDE_LIMIT_TENTHS = 12'sd0;

    localparam logic [TIME_W-1:0] PREHEAT_TIMEOUT_MS = 32'd600000;
    localparam logic [TIME_W-1:0] FIREPLACE_TIME_MS  = 32'd14400000;

    typedef struct packed {
        logic signed [TEMP_W-1:0] exhaust_temp;
        logic                     exhaust_valid;
        logic signed [TEMP_W-1:0] outside_temp;
        logic                     outside_valid;
        logic [TIME_W-1:0]        now_ms;
    } check_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              mode_changed;
        logic              supply_fan_off;
        logic              exhaust_fan_off;
        logic              preheater_regulating;
    } result_t;

    typedef struct packed {
        logic [HYST_W-1:0] hysteresis_degrees;
        logic              fireplace_installed;
    } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hxas_if.sv =====
// channel interfaces: check input, result output, register write
`timescale 1ns / 1ps
`default_nettype none
interface hxas_check_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [hxas_pkg::TEMP_W-1:0]       exhaust_temp;
    logic                                     exhaust_valid;
    logic signed [hxas_pkg::TEMP_W-1:0]       outside_temp;
    logic                                     outside_valid;
    logic [hxas_pkg::TIME_W-1:0]              now_ms;

    modport source (output valid, exhaust_temp, exhaust_valid, outside_temp,
                    outside_valid, now_ms, input ready);
    modport sink (input valid, exhaust_temp, exhaust_valid, outside_temp,
                  outside_valid, now_ms, output ready);
endinterface

interface hxas_result_if;
    logic                          valid;
    logic                          ready;
    logic [hxas_pkg::MODE_W-1:0]   mode;
    logic                          mode_changed;
    logic                          supply_fan_off;
    logic                          exhaust_fan_off;
    logic                          preheater_regulating;

    modport source (output valid, mode, mode_changed, supply_fan_off,
                    exhaust_fan_off, preheater_regulating, input ready);
    modport sink (input valid, mode, mode_changed, supply_fan_off,
                  exhaust_fan_off, preheater_regulating, output ready);
endinterface

interface hxas_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [hxas_pkg::CFG_IDX_W-1:0]    index;
    logic [hxas_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/hxas_cfg.sv =====
// configuration registers with hysteresis saturation
`timescale 1ns / 1ps
`default_nettype none
module hxas_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hxas_cfg_if.sink           cfg,
    output hxas_pkg::cfg_t     cfg_out
);

    logic [hxas_pkg::HYST_W-1:0] hyst_reg;
    logic [hxas_pkg::HYST_W-1:0] hyst_next;
    logic                        fireplace_reg;
    logic                        fireplace_next;
    logic                        wr;

    assign cfg.ready = 1'b1;
    assign wr = cfg.valid && cfg.ready;

    always_comb
    begin
        hyst_next = hyst_reg;
        fireplace_next = fireplace_reg;
        if (wr)
        begin
            case (cfg.index)
                hxas_pkg::CFG_HYSTERESIS:
                begin
                    hyst_next = (cfg.data > hxas_pkg::HYST_MAX) ? hxas_pkg::HYST_MAX
                                                                : cfg.data;
                end
                hxas_pkg::CFG_FIREPLACE:
                begin
                    fireplace_next = cfg.data[0];
                end
                default:
                begin
                    hyst_next = hyst_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg <= hxas_pkg::HYST_RESET;
            fireplace_reg <= 1'b0;
        end
        else
        begin
            hyst_reg <= hyst_next;
            fireplace_reg <= fireplace_next;
        end
    end

    assign cfg_out.hysteresis_degrees = hyst_reg;
    assign cfg_out.fireplace_installed = fireplace_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/hxas_fsm.sv =====
// mode state machine, start timestamps and result decode
`timescale 1ns / 1ps
`default_nettype none
module hxas_fsm (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire hxas_pkg::check_t  chk,
    input  wire hxas_pkg::cfg_t    cfg,
    output hxas_pkg::result_t      res
);

    logic [hxas_pkg::MODE_W-1:0] mode_reg;
    logic [hxas_pkg::MODE_W-1:0] mode_next;
    logic [hxas_pkg::TIME_W-1:0] preheat_start_reg;
    logic [hxas_pkg::TIME_W-1:0] preheat_start_next;
    logic [hxas_pkg::TIME_W-1:0] fireplace_start_reg;
    logic [hxas_pkg::TIME_W-1:0] fireplace_start_next;

    logic signed [hxas_pkg::TEMP_W-1:0] exit_level;
    logic [hxas_pkg::TIME_W-1:0]        preheat_age;
    logic [hxas_pkg::TIME_W-1:0]        fireplace_age;
    logic                               freeze;
    logic                               warm;

    // exit level = 15 + 10 * h, h at most 10
    assign exit_level = hxas_pkg::THRESHOLD_TENTHS
                      + $signed({5'd0, cfg.hysteresis_degrees, 3'd0})
                      + $signed({7'd0, cfg.hysteresis_degrees, 1'b0});

    assign freeze = chk.exhaust_valid && chk.outside_valid
                 && (chk.exhaust_temp <= hxas_pkg::THRESHOLD_TENTHS)
                 && (chk.outside_temp < hxas_pkg::OUTSIDE_LIMIT_TENTHS);
    assign warm = chk.exhaust_valid && (chk.exhaust_temp > exit_level);

    // wrapping differences
    assign preheat_age = chk.now_ms - preheat_start_reg;
    assign fireplace_age = chk.now_ms - fireplace_start_reg;

    always_comb
    begin
        mode_next = mode_reg;
        preheat_start_next = preheat_start_reg;
        fireplace_start_next = fireplace_start_reg;
        case (mode_reg)
            hxas_pkg::MODE_OFF:
            begin
                if (freeze)
                begin
                    mode_next = hxas_pkg::MODE_PREHEATER;
                    preheat_start_next = chk.now_ms;
                end
            end
            hxas_pkg::MODE_PREHEATER:
            begin
                if (warm)
                begin
                    mode_next = hxas_pkg::MODE_OFF;
                end
                else if (preheat_age > hxas_pkg::PREHEAT_TIMEOUT_MS && freeze)
                begin
                    if (cfg.fireplace_installed)
                    begin
                        mode_next = hxas_pkg::MODE_FIREPLACE;
                        fireplace_start_next = chk.now_ms;
                    end
                    else
                    begin
                        mode_next = hxas_pkg::MODE_FAN_OFF;
                    end
                end
            end
            hxas_pkg::MODE_FAN_OFF:
            begin
                if (warm)
                begin
                    mode_next = hxas_pkg::MODE_OFF;
                end
            end
            default:
            begin
                if (fireplace_age > hxas_pkg::FIREPLACE_TIME_MS)
                begin
                    mode_next = hxas_pkg::MODE_OFF;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= hxas_pkg::MODE_OFF;
            preheat_start_reg <= '0;
            fireplace_start_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            preheat_start_reg <= preheat_start_next;
            fireplace_start_reg <= fireplace_start_next;
        end
    end

    assign res.mode = mode_next;
    assign res.mode_changed = (mode_next != mode_reg);
    assign res.supply_fan_off = (mode_next == hxas_pkg::MODE_FAN_OFF)
                             || (mode_next == hxas_pkg::MODE_FIREPLACE);
    assign res.exhaust_fan_off = (mode_next == hxas_pkg::MODE_FIREPLACE);
    assign res.preheater_regulating = (mode_next == hxas_pkg::MODE_PREHEATER);

    // state moves only on a processed beat
    a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(mode_reg))
        else $error("mode changed without a beat");

    // fireplace is reached only from preheater with a fireplace configured
    a_fireplace_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg != hxas_pkg::MODE_FIREPLACE
              && mode_next == hxas_pkg::MODE_FIREPLACE)
        |-> (mode_reg == hxas_pkg::MODE_PREHEATER && cfg.fireplace_installed))
        else $error("illegal entry to fireplace mode");

    // preheat start timestamp is taken only when leaving off
    a_preheat_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg != hxas_pkg::MODE_OFF) |=> $stable(preheat_start_reg))
        else $error("preheat start moved outside off mode");

    // fan-off mode never jumps straight to fireplace or preheater
    a_fan_off_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (step && mode_reg == hxas_pkg::MODE_FAN_OFF)
        |-> (mode_next == hxas_pkg::MODE_FAN_OFF || mode_next == hxas_pkg::MODE_OFF))
        else $error("bad exit from supply fan off mode");

endmodule
`default_nettype wire

// ===== hw/rtl/heat_exchanger_antifreeze_sequencer.sv =====
// top level: input register, mode state machine, result register
// Antifreeze sequencer for a ventilation heat exchanger.
// chk carries one periodic check per beat: exhaust and outside temperature
// (signed tenths of a degree), a valid flag for each and a millisecond
// timestamp. res returns one beat per check: the new mode, a changed flag
// and the fan and preheater drive flags. cfg writes register 0 (hysteresis
// in whole degrees, saturated at 10) or register 1 (fireplace installed);
// other indexes are ignored. cfg is always ready; the user must see that it is
// written only while idle, which the block itself does not enforce. A check
// passes through the input register and then the result register; res valid
// rises once the mode decision is registered. Throughput is one check per
// cycle while res is not stalled, set by the single state update per cycle in
// the mode state machine. When res is stalled the result register holds and
// the input register, if empty, takes one more beat before chk ready drops.
// Reset puts the mode in off, clears both start timestamps, sets hysteresis
// to 3 and fireplace installed to 0, and empties both registers.
`timescale 1ns / 1ps
`default_nettype none
module heat_exchanger_antifreeze_sequencer (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hxas_check_if.sink     chk,
    hxas_result_if.source  res,
    hxas_cfg_if.sink       cfg
);

    hxas_pkg::cfg_t    cfg_val;
    hxas_pkg::check_t  chk_reg;
    hxas_pkg::check_t  chk_in;
    hxas_pkg::result_t res_reg;
    hxas_pkg::result_t res_calc;
    logic              chk_valid_reg;
    logic              res_valid_reg;
    logic              advance;
    logic              step;

    hxas_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    assign advance = !res_valid_reg || res.ready;
    assign step = chk_valid_reg && advance;
    assign chk.ready = !chk_valid_reg || advance;

    assign chk_in.exhaust_temp = chk.exhaust_temp;
    assign chk_in.exhaust_valid = chk.exhaust_valid;
    assign chk_in.outside_temp = chk.outside_temp;
    assign chk_in.outside_valid = chk.outside_valid;
    assign chk_in.now_ms = chk.now_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (chk.ready)
            begin
                chk_valid_reg <= chk.valid;
            end
            if (advance)
            begin
                res_valid_reg <= chk_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chk.valid && chk.ready)
        begin
            chk_reg <= chk_in;
        end
        if (step)
        begin
            res_reg <= res_calc;
        end
    end

    hxas_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .chk   (chk_reg),
        .cfg   (cfg_val),
        .res   (res_calc)
    );

    assign res.valid = res_valid_reg;
    assign res.mode = res_reg.mode;
    assign res.mode_changed = res_reg.mode_changed;
    assign res.supply_fan_off = res_reg.supply_fan_off;
    assign res.exhaust_fan_off = res_reg.exhaust_fan_off;
    assign res.preheater_regulating = res_reg.preheater_regulating;

endmodule
`default_nettype wire

// ===== verif/hxas_sequencer_checker.sv =====
// checker for the antifreeze sequencer: mode prediction and result comparison
`timescale 1ns / 1ps
module hxas_sequencer_checker
    import hxas_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    hxas_check_if     chk,
    hxas_result_if    res,
    hxas_cfg_if       cfg,
    output int        fail_count,
    output int        pending
);

    logic [MODE_W-1:0] mode_now;
    logic [TIME_W-1:0] preheat_at;
    logic [TIME_W-1:0] fireplace_at;
    logic [HYST_W-1:0] hysteresis;
    logic              fireplace_fitted;
    result_t           expected_results[$];
    int                results_seen;

    task automatic report_error(input string what);
        $display("%0t ns: result %0d: %s", $time, results_seen, what);
        fail_count++;
    endtask

    // one periodic check through the mode machine, updating its state
    function automatic result_t advance_mode(input check_t c);
        int                exhaust;
        int                outside;
        int                exit_tenths;
        logic              freeze;
        logic              warm;
        logic [TIME_W-1:0] elapsed;
        logic [MODE_W-1:0] next_mode;
        result_t           r;
        exhaust = $signed(c.exhaust_temp);
        outside = $signed(c.outside_temp);
        exit_tenths = THRESHOLD_TENTHS + 10 * int'(hysteresis);
        freeze = c.exhaust_valid && c.outside_valid && exhaust <= THRESHOLD_TENTHS
            && outside < OUTSIDE_LIMIT_TENTHS;
        // an invalid exhaust reading never counts as warm
        warm = c.exhaust_valid && exhaust > exit_tenths;
        next_mode = mode_now;
        case (mode_now)
            MODE_OFF:
            begin
                if (freeze)
                begin
                    next_mode = MODE_PREHEATER;
                    preheat_at = c.now_ms;
                end
            end
            MODE_PREHEATER:
            begin
                elapsed = c.now_ms - preheat_at;
                if (warm)
                    next_mode = MODE_OFF;
                else if (elapsed > PREHEAT_TIMEOUT_MS && freeze)
                begin
                    if (fireplace_fitted)
                    begin
                        next_mode = MODE_FIREPLACE;
                        fireplace_at = c.now_ms;
                    end
                    else
                        next_mode = MODE_FAN_OFF;
                end
            end
            MODE_FAN_OFF:
            begin
                if (warm)
                    next_mode = MODE_OFF;
            end
            default:
            begin
                // fireplace ends on time alone
                elapsed = c.now_ms - fireplace_at;
                if (elapsed > FIREPLACE_TIME_MS)
                    next_mode = MODE_OFF;
            end
        endcase
        r.mode = next_mode;
        r.mode_changed = (next_mode != mode_now);
        r.supply_fan_off = (next_mode == MODE_FAN_OFF) || (next_mode == MODE_FIREPLACE);
        r.exhaust_fan_off = (next_mode == MODE_FIREPLACE);
        r.preheater_regulating = (next_mode == MODE_PREHEATER);
        mode_now = next_mode;
        return r;
    endfunction

    task automatic compare_result(input result_t got, input result_t want);
        if (got.mode !== want.mode)
            report_error($sformatf("mode got %0d want %0d", got.mode, want.mode));
        if (got.mode_changed !== want.mode_changed)
            report_error($sformatf("mode_changed got %0b want %0b",
                got.mode_changed, want.mode_changed));
        if (got.supply_fan_off !== want.supply_fan_off)
            report_error($sformatf("supply_fan_off got %0b want %0b",
                got.supply_fan_off, want.supply_fan_off));
        if (got.exhaust_fan_off !== want.exhaust_fan_off)
            report_error($sformatf("exhaust_fan_off got %0b want %0b",
                got.exhaust_fan_off, want.exhaust_fan_off));
        if (got.preheater_regulating !== want.preheater_regulating)
            report_error($sformatf("preheater_regulating got %0b want %0b",
                got.preheater_regulating, want.preheater_regulating));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        check_t  beat;
        if (!rst_n)
        begin
            mode_now = MODE_OFF;
            preheat_at = '0;
            fireplace_at = '0;
            hysteresis = HYST_RESET;
            fireplace_fitted = 1'b0;
            expected_results.delete();
            results_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_HYSTERESIS: hysteresis = (cfg.data > HYST_MAX) ? HYST_MAX : cfg.data;
                    CFG_FIREPLACE:  fireplace_fitted = cfg.data[0];
                    default:        ;
                endcase
            end
            // results leave only after their check has passed both registers, so pop before push
            if (res.valid && res.ready)
            begin
                got.mode = res.mode;
                got.mode_changed = res.mode_changed;
                got.supply_fan_off = res.supply_fan_off;
                got.exhaust_fan_off = res.exhaust_fan_off;
                got.preheater_regulating = res.preheater_regulating;
                if (expected_results.size() == 0)
                    report_error($sformatf("unexpected beat, mode %0d", got.mode));
                else
                    compare_result(got, expected_results.pop_front());
                results_seen++;
            end
            if (chk.valid && chk.ready)
            begin
                beat.exhaust_temp = chk.exhaust_temp;
                beat.exhaust_valid = chk.exhaust_valid;
                beat.outside_temp = chk.outside_temp;
                beat.outside_valid = chk.outside_valid;
                beat.now_ms = chk.now_ms;
                expected_results.push_back(advance_mode(beat));
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== verif/tb_heat_exchanger_antifreeze_sequencer.sv =====
// testbench top for the antifreeze sequencer: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_heat_exchanger_antifreeze_sequencer;
    import hxas_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int RANDOM_PHASES    = 8;
    localparam int CHECKS_PER_PHASE = 100;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 100000;
    localparam logic [TIME_W-1:0] NEAR_WRAP = 32'hFFFF_0000;

    logic              clk = 1'b0;
    logic              rst_n;
    int                cycles = 0;
    int                fail_count;
    int                pending;
    logic              long_hold = 1'b0;
    logic              chk_steady = 1'b0;
    logic              res_steady = 1'b0;
    int                exit_tenths;
    logic [TIME_W-1:0] clock_ms;

    hxas_check_if  chk_if();
    hxas_result_if res_if();
    hxas_cfg_if    cfg_if();

    heat_exchanger_antifreeze_sequencer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .chk   (chk_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    hxas_sequencer_checker sequencer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .chk        (chk_if),
        .res        (res_if),
        .cfg        (cfg_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("heat_exchanger_antifreeze_sequencer regression: fail");
            $finish;
        end
    end

    function automatic check_t make_check(input int exhaust, input logic exhaust_ok,
                                          input int outside, input logic outside_ok,
                                          input logic [TIME_W-1:0] stamp);
        check_t c;
        c.exhaust_temp = exhaust[TEMP_W-1:0];
        c.exhaust_valid = exhaust_ok;
        c.outside_temp = outside[TEMP_W-1:0];
        c.outside_valid = outside_ok;
        c.now_ms = stamp;
        return c;
    endfunction

    // mostly plausible weather with a drifting clock, some noise
    function automatic check_t random_check();
        int   pick;
        int   exhaust;
        int   outside;
        logic exhaust_ok;
        logic outside_ok;
        pick = $urandom_range(0, 99);
        exhaust_ok = 1'b1;
        outside_ok = 1'b1;
        if (pick < 45)
        begin
            exhaust = 15 - int'($urandom_range(0, 415));
            outside = -1 - int'($urandom_range(0, 400));
        end
        else if (pick < 65)
        begin
            exhaust = exit_tenths - 2 + int'($urandom_range(0, 40));
            outside = int'($urandom_range(0, 600)) - 300;
            outside_ok = $urandom_range(0, 1);
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 3))
                0:       exhaust = 15;
                1:       exhaust = 16;
                2:       exhaust = exit_tenths;
                default: exhaust = exit_tenths + 1;
            endcase
            outside = $urandom_range(0, 1) ? -1 : 0;
        end
        else if (pick < 85)
        begin
            exhaust = int'($urandom_range(0, 4095)) - 2048;
            outside = -1 - int'($urandom_range(0, 100));
            exhaust_ok = $urandom_range(0, 1);
            outside_ok = exhaust_ok ? 1'b0 : 1'($urandom_range(0, 1));
        end
        else
        begin
            exhaust = int'($urandom_range(0, 4095)) - 2048;
            outside = int'($urandom_range(0, 4095)) - 2048;
            exhaust_ok = $urandom_range(0, 1);
            outside_ok = $urandom_range(0, 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45)
            clock_ms = clock_ms + $urandom_range(0, 60000);
        else if (pick < 70)
            clock_ms = clock_ms + $urandom_range(100000, 700000);
        else if (pick < 80)
            clock_ms = clock_ms + PREHEAT_TIMEOUT_MS + $urandom_range(0, 1);
        else if (pick < 90)
            clock_ms = clock_ms + FIREPLACE_TIME_MS + $urandom_range(0, 1);
        else if (pick < 95)
            clock_ms = $urandom();
        return make_check(exhaust, exhaust_ok, outside, outside_ok, clock_ms);
    endfunction

    task automatic send_check(input check_t c);
        int gap;
        gap = chk_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            chk_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chk_if.valid <= 1'b1;
        chk_if.exhaust_temp <= c.exhaust_temp;
        chk_if.exhaust_valid <= c.exhaust_valid;
        chk_if.outside_temp <= c.outside_temp;
        chk_if.outside_valid <= c.outside_valid;
        chk_if.now_ms <= c.now_ms;
        do @(posedge clk); while (!chk_if.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data <= data;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    task automatic set_registers(input logic [HYST_W-1:0] hyst, input logic fitted,
                                 input logic spare_too);
        logic [CFG_DATA_W-1:0] fit_word;
        fit_word = $urandom();
        fit_word[0] = fitted;
        write_reg(CFG_HYSTERESIS, hyst);
        write_reg(CFG_FIREPLACE, fit_word);
        if (spare_too)
        begin
            write_reg(CFG_SPARE_A, $urandom());
            write_reg(CFG_SPARE_B, $urandom());
        end
        cfg_if.valid <= 1'b0;
        exit_tenths = THRESHOLD_TENTHS + 10 * int'((hyst > HYST_MAX) ? HYST_MAX : hyst);
    endtask

    // lets every outstanding result come back before the next register write
    task automatic drain();
        chk_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial
    begin
        int stall;
        res_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                stall = res_steady ? 0 : $urandom_range(0, 3);
                if (stall > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
        end
    end

    initial
    begin
        logic [HYST_W-1:0] hyst_pick;
        logic              fitted_pick;
        logic              spare_pick;
        logic [TIME_W-1:0] fire_at;
        rst_n = 1'b0;
        chk_if.valid = 1'b0;
        chk_if.exhaust_temp = '0;
        chk_if.exhaust_valid = 1'b0;
        chk_if.outside_temp = '0;
        chk_if.outside_valid = 1'b0;
        chk_if.now_ms = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fireplace fitted, default hysteresis, timestamps across the wrap
        set_registers(4'd3, 1'b1, 1'b0);
        fire_at = NEAR_WRAP + PREHEAT_TIMEOUT_MS + 1;
        send_check(make_check(-300, 1'b0, -300, 1'b1, NEAR_WRAP));
        send_check(make_check(-300, 1'b1, -300, 1'b0, NEAR_WRAP));
        send_check(make_check(15, 1'b1, -1, 1'b1, NEAR_WRAP));
        send_check(make_check(2047, 1'b0, -1, 1'b1, NEAR_WRAP + 1000));
        send_check(make_check(15, 1'b1, -1, 1'b1, NEAR_WRAP + PREHEAT_TIMEOUT_MS));
        send_check(make_check(15, 1'b1, 0, 1'b1, fire_at));
        send_check(make_check(-2048, 1'b1, -2048, 1'b1, fire_at));
        send_check(make_check(2047, 1'b1, 2047, 1'b1, fire_at + FIREPLACE_TIME_MS));
        send_check(make_check(-2048, 1'b1, -2048, 1'b1, fire_at + FIREPLACE_TIME_MS + 1));
        send_check(make_check(16, 1'b1, -1, 1'b1, 32'd5));
        send_check(make_check(15, 1'b1, -1, 1'b1, 32'd6));
        send_check(make_check(45, 1'b1, -1, 1'b1, 32'd7));
        send_check(make_check(46, 1'b1, -1, 1'b1, 32'd8));
        drain();

        // hysteresis written above ten, fan-off path
        set_registers(4'd15, 1'b0, 1'b1);
        send_check(make_check(-100, 1'b1, -500, 1'b1, 32'd0));
        send_check(make_check(115, 1'b1, -1, 1'b1, 32'd10));
        send_check(make_check(-100, 1'b1, -1, 1'b1, PREHEAT_TIMEOUT_MS + 1));
        send_check(make_check(2047, 1'b0, -1, 1'b1, PREHEAT_TIMEOUT_MS + 2));
        send_check(make_check(116, 1'b1, -2048, 1'b0, PREHEAT_TIMEOUT_MS + 3));
        drain();

        // zero hysteresis
        set_registers(4'd0, 1'b0, 1'b1);
        send_check(make_check(15, 1'b1, -1, 1'b1, 32'hFFFF_FFFF));
        send_check(make_check(16, 1'b1, 5, 1'b1, 32'h0));
        send_check(make_check(2047, 1'b1, 2047, 1'b1, 32'hFFFF_FFFF));
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    hyst_pick = 4'd0;
                    fitted_pick = 1'b0;
                end
                1:
                begin
                    hyst_pick = HYST_MAX;
                    fitted_pick = 1'b1;
                end
                2:
                begin
                    hyst_pick = 4'd15;
                    fitted_pick = 1'b1;
                end
                3:
                begin
                    hyst_pick = HYST_RESET;
                    fitted_pick = 1'b0;
                end
                default:
                begin
                    hyst_pick = $urandom_range(0, 15);
                    fitted_pick = $urandom_range(0, 1);
                end
            endcase
            spare_pick = $urandom_range(0, 1);
            set_registers(hyst_pick, fitted_pick, spare_pick);
            chk_steady = (p % 4 == 3);
            res_steady = (p % 4 == 2) || (p % 4 == 3);
            // receiver stalls long enough for the block to back up its input
            long_hold = (p == 1);
            clock_ms = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 2000000)
                                            : $urandom();
            for (int n = 0; n < CHECKS_PER_PHASE; n++)
                send_check(random_check());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("heat_exchanger_antifreeze_sequencer regression: pass");
        else
            $display("heat_exchanger_antifreeze_sequencer regression: fail");
        $finish;
    end

endmodule
